// ----- hdl/ssms_pkg.sv -----
// Shared types and constants for the stock span monotonic stack.
`default_nettype none
package ssms_pkg;

  localparam int PRICE_W = 32;
  localparam int SPAN_W  = 11;

  // Stack move command broadcast to every slot in the chain
  typedef struct packed {
    logic push;
    logic pop;
  } ssms_shift_t;

endpackage
`default_nettype wire

// ----- hdl/ssms_in_if.sv -----
// Input channel interface: first-item flag and price.
`default_nettype none
interface ssms_in_if
  import ssms_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               first_item;
  logic [PRICE_W-1:0] price;

  modport source (output valid, output first_item, output price, input ready);
  modport sink   (input valid, input first_item, input price, output ready);
endinterface
`default_nettype wire

// ----- hdl/ssms_out_if.sv -----
// Result channel interface: span and too-long flag.
`default_nettype none
interface ssms_out_if
  import ssms_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SPAN_W-1:0] span;
  logic              too_long;

  modport source (output valid, output span, output too_long, input ready);
  modport sink   (input valid, input span, input too_long, output ready);
endinterface
`default_nettype wire

// ----- hdl/ssms_slot.sv -----
// One stack slot: holds a value and its position, shifts with its neighbors.
`default_nettype none
module ssms_slot
  import ssms_pkg::*;
#(
  parameter int VAL_W = 32,
  parameter int POS_W = 10
) (
  input  wire logic             clk,
  input  wire ssms_shift_t      shift,
  input  wire logic [VAL_W-1:0] up_val,
  input  wire logic [POS_W-1:0] up_pos,
  input  wire logic [VAL_W-1:0] dn_val,
  input  wire logic [POS_W-1:0] dn_pos,
  output logic      [VAL_W-1:0] val,
  output logic      [POS_W-1:0] pos
);

  logic [VAL_W-1:0] val_r;
  logic [POS_W-1:0] pos_r;

  // Push takes the entry from above, pop takes the entry from below
  always_ff @(posedge clk) begin
    if (shift.push) begin
      val_r <= up_val;
      pos_r <= up_pos;
    end else if (shift.pop) begin
      val_r <= dn_val;
      pos_r <= dn_pos;
    end
  end

  assign val = val_r;
  assign pos = pos_r;

endmodule
`default_nettype wire

// ----- hdl/stock_span_monotonic_stack.sv -----
// Top level of the stock span block: control and the chain of stack slots.
`default_nettype none
// Stock span engine. For each accepted transaction (first_item, price) it
// returns one result transaction: span, the count of consecutive prices ending
// with this one that are <= it, and too_long, set (with span 0) for any item
// past MAX_LEN in the current sequence. first_item clears the stack and starts
// a new sequence; after reset the stream already counts as a fresh sequence.
// The stack lives in a row of MAX_LEN slots with the top in slot 0; a push or
// pop shifts every slot by one place toward its neighbor. After acceptance an
// item pops its entries, one pop per cycle through the compare on slot 0,
// then loads its result into the output register once that register is
// free. Every entry is popped at most once, so a sequence never pops more
// entries than it pushed. The next item is accepted as soon as the result is
// loaded into the output register, while that result still waits to be taken.
module stock_span_monotonic_stack
  import ssms_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ssms_in_if.sink   in_ch,
  ssms_out_if.source out_ch
);

  localparam int CMP_W  = (VALUE_BITS < PRICE_W) ? VALUE_BITS : PRICE_W;
  localparam int POS_W  = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int CALC_W = (CNT_W > SPAN_W) ? CNT_W : SPAN_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CMP_W-1:0] v_r, v_nxt;
  logic             ovf_r, ovf_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SPAN_W-1:0] out_span_r, out_span_nxt;
  logic              out_long_r, out_long_nxt;

  ssms_shift_t shift;

  logic [CMP_W-1:0] slot_val [MAX_LEN];
  logic [POS_W-1:0] slot_pos [MAX_LEN];

  logic              in_fire;
  logic              out_free;
  logic              top_le;
  logic [CALC_W-1:0] span_wide;
  logic [CNT_W-1:0]  eff_pos;

  // Chain of slots; slot 0 is the top of stack and takes the new entry
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_slot
    if (i == 0) begin : g_top
      if (MAX_LEN > 1) begin : g_more
        ssms_slot #(.VAL_W(CMP_W), .POS_W(POS_W)) u_slot (
          .clk   (clk),
          .shift (shift),
          .up_val(v_r),
          .up_pos(pos_r[POS_W-1:0]),
          .dn_val(slot_val[1]),
          .dn_pos(slot_pos[1]),
          .val   (slot_val[0]),
          .pos   (slot_pos[0])
        );
      end
    end else if (i == MAX_LEN - 1) begin : g_bottom
      // Bottom slot has nothing below it; keep its own entry on a pop
      ssms_slot #(.VAL_W(CMP_W), .POS_W(POS_W)) u_slot (
        .clk   (clk),
        .shift (shift),
        .up_val(slot_val[i-1]),
        .up_pos(slot_pos[i-1]),
        .dn_val(slot_val[i]),
        .dn_pos(slot_pos[i]),
        .val   (slot_val[i]),
        .pos   (slot_pos[i])
      );
    end else begin : g_mid
      ssms_slot #(.VAL_W(CMP_W), .POS_W(POS_W)) u_slot (
        .clk   (clk),
        .shift (shift),
        .up_val(slot_val[i-1]),
        .up_pos(slot_pos[i-1]),
        .dn_val(slot_val[i+1]),
        .dn_pos(slot_pos[i+1]),
        .val   (slot_val[i]),
        .pos   (slot_pos[i])
      );
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;

  // Top entry is popped while it is <= the new value (offset binary compare)
  assign top_le = (count_r != '0) && (slot_val[0] <= v_r);

  always_comb begin
    if (count_r == '0) begin
      span_wide = CALC_W'(pos_r) + CALC_W'(1);
    end else begin
      span_wide = CALC_W'(pos_r) - CALC_W'(slot_pos[0]);
    end
  end

  assign eff_pos = in_ch.first_item ? '0 : pos_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    v_nxt         = v_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_span_nxt  = out_span_r;
    out_long_nxt  = out_long_r;
    shift         = '0;

    // Drop the held result once it is taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // Latch the value in offset binary so an unsigned compare orders it
          v_nxt = in_ch.price[CMP_W-1:0] ^ {1'b1, {(CMP_W-1){1'b0}}};
          ovf_nxt = (eff_pos >= CNT_W'(MAX_LEN));
          if (in_ch.first_item) begin
            count_nxt = '0;
            pos_nxt   = '0;
          end
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!ovf_r && top_le) begin
          shift.pop = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end else if (out_free) begin
          // Hold here until the output register is free, then finish the item
          out_valid_nxt = 1'b1;
          if (ovf_r) begin
            out_span_nxt = '0;
            out_long_nxt = 1'b1;
          end else begin
            out_span_nxt = span_wide[SPAN_W-1:0];
            out_long_nxt = 1'b0;
            shift.push   = 1'b1;
            count_nxt    = count_r + CNT_W'(1);
            pos_nxt      = pos_r + CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    ovf_r      <= ovf_nxt;
    out_span_r <= out_span_nxt;
    out_long_r <= out_long_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.span     = out_span_r;
  assign out_ch.too_long = out_long_r;

endmodule
`default_nettype wire

// ----- tb/sv/stock_span_monotonic_stack_tb.sv -----
// Self-checking testbench for the stock span monotonic stack block.
`timescale 1ns / 1ps

module stock_span_monotonic_stack_tb;
  import ssms_pkg::*;

  // Must track the block's default parameters.
  localparam int MAX_LEN         = 1024;
  localparam int ENTRY_POS_W     = $clog2(MAX_LEN);
  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_ITEMS  = 12;
  // Worst quiet stretch: one item popping a full stack while the receiver
  // sits in a long hold-off, plus sender gaps. Take it several times over.
  localparam int WATCHDOG_LIMIT  = 4 * (MAX_LEN + 2 + HOLD_OFF_CYCLES + 64);
  // Latency allowance after the last result: one item popping a full stack.
  localparam int TAIL_CYCLES     = MAX_LEN + 8;
  localparam int SHORT_PHASE_ITEMS = 110;
  localparam int FALLING_RUN     = 600;

  // One result transaction as the block should produce it.
  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic              too_long;
  } span_result_t;

  // Row of the directed table. When known is set, span is the value read
  // straight off the behavior; otherwise the predictor supplies it.
  typedef struct packed {
    logic               is_first;
    logic [PRICE_W-1:0] price;
    logic               known;
    logic [SPAN_W-1:0]  span;
  } dir_row_t;

  typedef enum logic [2:0] {
    PX_WIDE,
    PX_NARROW,
    PX_RISING,
    PX_FALLING,
    PX_EXTREME
  } price_style_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
    // no first_item after reset: stream starts at element 0
    '{1'b0, 32'h0000_0000, 1'b1, 11'd1},
    '{1'b0, 32'h8000_0000, 1'b1, 11'd1},   // most negative price
    '{1'b0, 32'h7FFF_FFFF, 1'b1, 11'd3},   // most positive pops everything
    '{1'b0, 32'h7FFF_FFFF, 1'b1, 11'd4},   // equal price counts in the span
    '{1'b1, 32'h8000_0000, 1'b1, 11'd1},   // restart on the minimum
    '{1'b0, 32'h8000_0000, 1'b1, 11'd2},
    '{1'b0, 32'h8000_0000, 1'b1, 11'd3},
    '{1'b1, 32'h0000_000A, 1'b0, 11'd0},
    '{1'b0, 32'h0000_0007, 1'b0, 11'd0},
    '{1'b0, 32'h0000_0007, 1'b0, 11'd0},
    '{1'b0, 32'h0000_0003, 1'b0, 11'd0},
    '{1'b0, 32'h0000_0008, 1'b0, 11'd0},
    '{1'b0, 32'hFFFF_FFFF, 1'b0, 11'd0},
    '{1'b0, 32'h0000_000F, 1'b0, 11'd0},
    '{1'b0, 32'h0000_0000, 1'b0, 11'd0},
    '{1'b0, 32'h0000_0064, 1'b0, 11'd0},
    '{1'b1, 32'h5555_5555, 1'b0, 11'd0},
    '{1'b0, 32'hAAAA_AAAA, 1'b0, 11'd0},
    '{1'b0, 32'hFFFF_FFFE, 1'b0, 11'd0},
    '{1'b0, 32'hFFFF_FFFF, 1'b0, 11'd0},
    '{1'b1, 32'h7FFF_FFFF, 1'b1, 11'd1},
    '{1'b1, 32'h7FFF_FFFF, 1'b1, 11'd1},   // back-to-back restarts
    '{1'b0, 32'h0000_0001, 1'b0, 11'd0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ssms_in_if  in_ch ();
  ssms_out_if out_ch ();

  stock_span_monotonic_stack u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Predictor state: the monotonic stack kept in offset-binary order keys,
  // the positions of those entries, and the index of the next element.
  logic [PRICE_W-1:0]     order_keys [MAX_LEN];
  logic [ENTRY_POS_W-1:0] entry_pos  [MAX_LEN];
  int                     stack_depth = 0;
  int                     seq_index   = 0;

  span_result_t expected_spans [$];

  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned too_long_seen = 0;
  int unsigned max_span_seen = 0;
  int unsigned mismatches    = 0;
  int unsigned holds_done    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned burst_left    = 0;
  bit          hold_off_req  = 1'b0;

  // Advance the predicted stack by one element and return its result.
  function automatic span_result_t span_predict(input logic is_first,
                                                input logic [PRICE_W-1:0] price);
    logic [PRICE_W-1:0] key;
    span_result_t       res;
    res.span     = '0;
    res.too_long = 1'b0;
    if (is_first) begin
      stack_depth = 0;
      seq_index   = 0;
    end
    // Past the length limit nothing changes; the result is flagged.
    if (seq_index >= MAX_LEN) begin
      res.too_long = 1'b1;
      return res;
    end
    // Flip the sign bit so an unsigned compare follows signed order.
    key = price ^ {1'b1, {(PRICE_W-1){1'b0}}};
    // Drop every older entry that is not above this price (ties included).
    while (stack_depth > 0 && order_keys[stack_depth-1] <= key)
      stack_depth--;
    if (stack_depth == 0)
      res.span = SPAN_W'(seq_index + 1);
    else
      res.span = SPAN_W'(seq_index - int'(entry_pos[stack_depth-1]));
    if (stack_depth < MAX_LEN) begin
      order_keys[stack_depth] = key;
      entry_pos[stack_depth]  = ENTRY_POS_W'(seq_index);
      stack_depth++;
    end
    seq_index++;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: result %0d mismatch: %s", $realtime, results_seen, what);
  endtask

  // Offer one transaction and hold it until the block takes it, then record
  // what the block owes for it.
  task automatic send_item(input logic is_first, input logic [PRICE_W-1:0] price,
                           input logic known, input logic [SPAN_W-1:0] known_span);
    span_result_t predicted;
    in_ch.valid      <= 1'b1;
    in_ch.first_item <= is_first;
    in_ch.price      <= price;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = span_predict(is_first, price);
    if (known) begin
      predicted.span     = known_span;
      predicted.too_long = 1'b0;
    end
    expected_spans.push_back(predicted);
    items_sent++;
  endtask

  // Sender pacing: bursts of random length separated by random gaps. Three in
  // ten of the gaps are zero so bursts run together into unbroken stretches.
  task automatic sender_pace();
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Pause the sender until every owed result has been taken.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic [PRICE_W-1:0] pick_price(input price_style_t style,
                                                    input logic [PRICE_W-1:0] prev);
    case (style)
      PX_WIDE:    return $urandom;
      PX_NARROW:  return $urandom_range(0, 8) - 4;      // many ties around zero
      PX_RISING:  return prev + $urandom_range(0, 40);
      PX_FALLING: return prev - $urandom_range(0, 40);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // Short sequences of mixed shape. Most open with first_item; a few carry
  // on from the previous sequence, and a rare mid-sequence restart is noise.
  // With with_hold set, the receiver is held off halfway while the sender
  // keeps pushing, so the block backs up and stalls its input.
  task automatic run_short_sequences(input int n_items, input bit with_hold);
    int                 count;
    int                 seq_len;
    int                 i;
    bit                 hold_sent;
    logic               is_first;
    price_style_t       style;
    logic [PRICE_W-1:0] price;
    count     = 0;
    hold_sent = 1'b0;
    price     = $urandom;
    while (count < n_items) begin
      seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 20);
      style   = price_style_t'($urandom_range(0, 4));
      for (i = 0; i < seq_len; i++) begin
        if (with_hold && !hold_sent && count >= n_items / 2) begin
          hold_off_req = 1'b1;
          repeat (HOLD_OFF_ITEMS) send_item(1'b0, $urandom, 1'b0, '0);
          hold_sent = 1'b1;
        end
        if (i == 0)
          is_first = ($urandom_range(0, 9) != 0);
        else
          is_first = ($urandom_range(0, 99) == 0);
        if ($urandom_range(0, 15) == 0)
          style = price_style_t'($urandom_range(0, 4));
        price = pick_price(style, price);
        sender_pace();
        send_item(is_first, price, 1'b0, '0);
        count++;
      end
    end
  endtask

  // One sequence of exactly MAX_LEN elements, then a few more. A long falling
  // run builds a deep stack, mixed shapes follow, and the last legal element
  // is the maximum price so it pops the whole stack and gets the widest span.
  // Further elements without first_item fall past the length limit.
  task automatic run_long_sequence();
    int                 i;
    price_style_t       style;
    logic [PRICE_W-1:0] price;
    price = 32'h7000_0000;
    style = PX_WIDE;
    for (i = 0; i < MAX_LEN; i++) begin
      if (i == MAX_LEN - 1)
        price = 32'h7FFF_FFFF;
      else if (i < FALLING_RUN)
        price = price - $urandom_range(0, 3000);
      else begin
        if (i % 64 == 0)
          style = price_style_t'($urandom_range(0, 4));
        price = pick_price(style, price);
      end
      sender_pace();
      send_item(i == 0, price, 1'b0, '0);
    end
    repeat (8) begin
      sender_pace();
      send_item(1'b0, $urandom, 1'b0, '0);
    end
  endtask

  // Receiver: ready follows a mode that is redrawn at random
  // (free-flowing, coin toss, sparse, fixed duty cycle). A hold-off request
  // from the stimulus drops ready for a long counted stretch.
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned tick;
    out_ch.ready = 1'b0;
    mode      = RX_FREE;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        holds_done++;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      tick++;
      case (mode)
        RX_FREE:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 7) == 0);
        default:   out_ch.ready <= ((tick % 13) < 8);
      endcase
    end
  end

  // Compare every result transaction with the oldest owed result.
  always @(posedge clk) begin : check_results
    span_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.too_long) too_long_seen++;
      if (32'(out_ch.span) > max_span_seen) max_span_seen = 32'(out_ch.span);
      if (expected_spans.size() == 0) begin
        report_mismatch($sformatf("unexpected result span %0d too_long %0b",
                                  out_ch.span, out_ch.too_long));
      end else begin
        want = expected_spans.pop_front();
        if (out_ch.span !== want.span)
          report_mismatch($sformatf("span %0d, predicted %0d", out_ch.span, want.span));
        if (out_ch.too_long !== want.too_long)
          report_mismatch($sformatf("too_long %0b, predicted %0b",
                                    out_ch.too_long, want.too_long));
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results still owed",
               WATCHDOG_LIMIT, expected_spans.size());
      $display("[stock_span_monotonic_stack] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    in_ch.valid      = 1'b0;
    in_ch.first_item = 1'b0;
    in_ch.price      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: extremes, ties, restarts, no restart after reset.
    foreach (DIRECTED[i]) begin
      sender_pace();
      send_item(DIRECTED[i].is_first, DIRECTED[i].price,
                DIRECTED[i].known, DIRECTED[i].span);
    end
    drain_results();

    run_short_sequences(SHORT_PHASE_ITEMS, 1'b1);
    // Let the block go fully idle before the full-length sequence.
    drain_results();
    run_long_sequence();
    run_short_sequences(SHORT_PHASE_ITEMS, 1'b0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_spans.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_spans.size()));

    $display("Covered %0d input and %0d result transactions, %0d past the length limit,",
             items_sent, results_seen, too_long_seen);
    $display("widest span %0d of %0d, %0d long receiver hold-offs, %0d mismatches.",
             max_span_seen, MAX_LEN, holds_done, mismatches);
    if (mismatches == 0) begin
      $display("[stock_span_monotonic_stack] OK");
    end else begin
      $display("[stock_span_monotonic_stack] ERROR");
    end
    $finish;
  end

endmodule
